>>> rtl/core/dcmt_pkg.sv
// Package for the down-counter millisecond timebase.
// Holds field widths, function and register codes, reset values and the
// command/status structs shared by the controller and the datapath.
package dcmt_pkg;

  localparam int CntW    = 24;
  localparam int RefW    = 32;
  localparam int MsW     = 32;
  localparam int TpuW    = 8;
  localparam int CfgW    = 24;
  localparam int CfgIdxW = 2;
  localparam int FuncW   = 2;
  localparam int DivW    = CntW + 1;
  localparam int DivCntW = $clog2(DivW + 1);
  localparam int ProdW   = RefW + TpuW;

  localparam logic [FuncW-1:0] FuncSync  = 2'd0;
  localparam logic [FuncW-1:0] FuncMsChk = 2'd1;
  localparam logic [FuncW-1:0] FuncUsChk = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgReload = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTpm    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTpu    = 2'd2;

  localparam logic [CfgW-1:0] ReloadRst = 24'hFF_FFFF;
  localparam logic [CfgW-1:0] TpmRst    = 24'd24000;
  localparam logic [TpuW-1:0] TpuRst    = 8'd24;

  typedef struct packed {
    logic latch;
    logic calc;
    logic load;
    logic step;
    logic upd;
    logic commit;
  } dcmt_cmd_t;

  typedef struct packed {
    logic upd;
    logic out_free;
  } dcmt_sts_t;

endpackage

>>> rtl/core/dcmt_ctrl.sv
// Controller for the millisecond timebase: sequences accept, distance,
// divide, update and result load. Uses dcmt_pkg.
module dcmt_ctrl
  import dcmt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  dcmt_sts_t  sts_i,
  output dcmt_cmd_t  cmd_o,
  output logic       busy_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StCalc = 3'd1;
  localparam logic [2:0] StLoad = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StUpd  = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = StCalc;
        end
      end
      StCalc: begin
        cmd_o.calc = 1'b1;
        state_d    = StLoad;
      end
      StLoad: begin
        if (sts_i.upd) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = StDiv;
        end else begin
          state_d = StDone;
        end
      end
      StDiv: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivW - 1)) begin
          state_d = StUpd;
        end
      end
      StUpd: begin
        cmd_o.upd = 1'b1;
        state_d   = StDone;
      end
      StDone: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = (state_q != StIdle);

endmodule

>>> rtl/core/dcmt_dp.sv
// Datapath for the millisecond timebase: config registers, timebase state,
// wrap distance, restoring divider and result register. Uses dcmt_pkg.
module dcmt_dp
  import dcmt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dcmt_cmd_t           cmd_i,
  output dcmt_sts_t           sts_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic [FuncW-1:0]    func_i,
  input  logic [CntW-1:0]     counter_value_i,
  input  logic [RefW-1:0]     ref_req_i,
  input  logic [RefW-1:0]     span_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [MsW-1:0]      ms_count_o,
  output logic                expired_o
);

  logic [CfgW-1:0]  reload_q;
  logic [CfgW-1:0]  tpm_q;
  logic [TpuW-1:0]  tpu_q;
  logic [CntW-1:0]  ref_tick_q;
  logic [MsW-1:0]   millis_q;

  logic [FuncW-1:0] func_q;
  logic [CntW-1:0]  now_q;
  logic [RefW-1:0]  rq_q;
  logic [RefW-1:0]  span_q;

  logic [RefW-1:0]  dist_q;
  logic [ProdW-1:0] prod_q;
  logic             upd_q;
  logic             ne_q;
  logic             hit1_q;

  logic [DivW-1:0]  quo_q;
  logic [CntW-1:0]  rem_q;
  logic [DivW-1:0]  used_q;

  logic             out_valid_q;
  logic [MsW-1:0]   ms_count_q;
  logic             expired_q;

  logic [DivW-1:0]  period;
  logic [RefW-1:0]  dist_r;
  logic [RefW-1:0]  dist_d;
  logic [DivW:0]    trial;
  logic             qbit;
  logic [CntW-1:0]  rem_d;
  logic [DivW:0]    ref_e, used_e, wrap_e;
  logic [CntW-1:0]  ref_tick_d;
  logic [MsW-1:0]   millis_d;
  logic             hit;
  logic             out_free;

  function automatic logic [RefW-1:0] down_dist(input logic [RefW-1:0] r,
                                                input logic [CntW-1:0] now,
                                                input logic [DivW-1:0] per);
    logic [RefW:0] now_x;
    logic [RefW:0] sum;
    now_x = (RefW+1)'(now);
    sum   = (RefW+1)'(per) + (RefW+1)'(r);
    if ((RefW+1)'(r) > now_x) begin
      return RefW'((RefW+1)'(r) - now_x);
    end else if (sum < now_x) begin
      return '0;
    end else begin
      return RefW'(sum - now_x);
    end
  endfunction

  assign period = DivW'(reload_q) + DivW'(1);
  assign dist_r = (func_q == FuncSync) ? RefW'(ref_tick_q) : rq_q;
  assign dist_d = down_dist(dist_r, now_q, period);

  assign trial = {1'b0, rem_q, quo_q[DivW-1]};
  assign qbit  = (trial >= (DivW+1)'(tpm_q));
  assign rem_d = qbit ? CntW'(trial - (DivW+1)'(tpm_q)) : CntW'(trial);

  assign ref_e  = (DivW+1)'(ref_tick_q);
  assign used_e = (DivW+1)'(used_q);
  assign wrap_e = (DivW+1)'(period) + ref_e;

  always_comb begin
    ref_tick_d = ref_tick_q;
    millis_d   = millis_q;
    if (upd_q) begin
      millis_d = millis_q + MsW'(quo_q);
      if (ref_e >= used_e) begin
        ref_tick_d = CntW'(ref_e - used_e);
      end else if (wrap_e >= used_e) begin
        ref_tick_d = CntW'(wrap_e - used_e);
      end else begin
        ref_tick_d = '0;
      end
    end
  end

  always_comb begin
    case (func_q)
      FuncMsChk: hit = hit1_q;
      FuncUsChk: hit = ne_q && (ProdW'(dist_q) >= prod_q);
      default:   hit = 1'b0;
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= ReloadRst;
      tpm_q    <= TpmRst;
      tpu_q    <= TpuRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgReload: reload_q <= cfg_wdata_i;
        CfgTpm:    tpm_q    <= cfg_wdata_i;
        CfgTpu:    tpu_q    <= TpuW'(cfg_wdata_i);
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_tick_q  <= '1;
      millis_q    <= '0;
      out_valid_q <= 1'b0;
      upd_q       <= 1'b0;
    end else begin
      if (cmd_i.calc) begin
        upd_q <= (func_q == FuncSync) && (ref_tick_q != now_q) && (tpm_q != '0);
      end
      if (cmd_i.commit) begin
        ref_tick_q  <= ref_tick_d;
        millis_q    <= millis_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q <= func_i;
      now_q  <= counter_value_i;
      rq_q   <= ref_req_i;
      span_q <= span_i;
    end
    if (cmd_i.calc) begin
      dist_q <= dist_d;
      prod_q <= ProdW'(span_q) * ProdW'(tpu_q);
      ne_q   <= (rq_q != RefW'(now_q));
      hit1_q <= ((millis_q - rq_q) >= span_q);
    end
    if (cmd_i.load) begin
      quo_q <= DivW'(dist_q);
      rem_q <= '0;
    end else if (cmd_i.step) begin
      quo_q <= {quo_q[DivW-2:0], qbit};
      rem_q <= rem_d;
    end
    if (cmd_i.upd) begin
      used_q <= DivW'(dist_q) - DivW'(rem_q);
    end
    if (cmd_i.commit) begin
      ms_count_q <= millis_d;
      expired_q  <= hit;
    end
  end

  assign sts_o.upd      = upd_q;
  assign sts_o.out_free = out_free;
  assign out_valid_o    = out_valid_q;
  assign ms_count_o     = ms_count_q;
  assign expired_o      = expired_q;

endmodule

>>> rtl/core/down_counter_ms_timebase_core.sv
// Top level of the down-counter millisecond timebase.
// Joins dcmt_ctrl and dcmt_dp; uses dcmt_pkg.
//
// Input channel (in_valid_i / in_stall_o) carries one item: func_i,
// counter_value_i, ref_req_i, span_i. func 0 syncs the millisecond count
// from a counter sample, func 1 checks a millisecond span, func 2 checks a
// microsecond span against the counter. Every item gives one result item
// on the output channel (out_valid_o / out_stall_i): ms_count_o, expired_o.
// The block works on one item at a time. A sync item whose sample differs
// from the reference tick, with ticks_per_ms nonzero, passes through the
// 25-step restoring divider (one quotient bit per cycle) between accept and
// result; every other item skips the divider. The next item is accepted in
// the cycle after the result is loaded.
// The result register is separate, so an item is accepted and worked on
// while a result still waits; a stalled receiver holds the block in its
// final step until the result register frees.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) go straight to
// the registers. Reset restores the register defaults, sets the reference
// tick to all ones and clears the millisecond count.
module down_counter_ms_timebase_core
  import dcmt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [FuncW-1:0]    func_i,
  input  logic [CntW-1:0]     counter_value_i,
  input  logic [RefW-1:0]     ref_req_i,
  input  logic [RefW-1:0]     span_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [MsW-1:0]      ms_count_o,
  output logic                expired_o
);

  dcmt_cmd_t cmd;
  dcmt_sts_t sts;
  logic      busy;

  dcmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  dcmt_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .func_i          (func_i),
    .counter_value_i (counter_value_i),
    .ref_req_i       (ref_req_i),
    .span_i          (span_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .ms_count_o      (ms_count_o),
    .expired_o       (expired_o)
  );

  assign in_stall_o = busy;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item accepted but controller not busy");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_valid_o || !out_stall_i))
    else $error("result loaded over a stalled result");

  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> (out_valid_o && !in_stall_o))
    else $error("result not presented after load");

  a_sync_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.commit && sts.upd) |=> !expired_o)
    else $error("sync item reported expired");

endmodule

>>> dv/dcmt_timebase_checker.sv
// Checker for the down-counter millisecond timebase: watches the config port
// and both item channels, predicts each result and compares it field by field.
// Depends on dcmt_pkg for widths, function codes and register indexes.
module dcmt_timebase_checker
  import dcmt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic [FuncW-1:0]   func_i,
  input  logic [CntW-1:0]    counter_value_i,
  input  logic [RefW-1:0]    ref_req_i,
  input  logic [RefW-1:0]    span_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic [MsW-1:0]     ms_count_o,
  input  logic               expired_o,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [MsW-1:0] ms_count;
    logic           expired;
  } ms_report_t;

  ms_report_t      report_q[$];
  logic [CfgW-1:0] reload_q;
  logic [CfgW-1:0] tpm_q;
  logic [TpuW-1:0] tpu_q;
  logic [CntW-1:0] ref_tick_q;
  logic [MsW-1:0]  millis_q;

  function automatic logic [63:0] down_ticks(input logic [63:0] from_tick,
                                             input logic [63:0] now_tick);
    logic [63:0] period;
    period = 64'(reload_q) + 64'd1;
    if (from_tick > now_tick) return from_tick - now_tick;
    if (period + from_tick < now_tick) return 64'd0;
    return period + from_tick - now_tick;
  endfunction

  task automatic predict_report(input logic [FuncW-1:0] func,
                                input logic [CntW-1:0]  sample,
                                input logic [RefW-1:0]  ref_req,
                                input logic [RefW-1:0]  span);
    logic [63:0] gap;
    logic [63:0] add;
    logic [63:0] used;
    logic [63:0] period;
    ms_report_t  rep;
    rep.expired = 1'b0;
    period = 64'(reload_q) + 64'd1;
    case (func)
      FuncSync: begin
        if (ref_tick_q != sample && tpm_q != '0) begin
          gap = down_ticks(64'(ref_tick_q), 64'(sample));
          if (gap >= 64'(tpm_q)) begin
            add  = gap / 64'(tpm_q);
            used = add * 64'(tpm_q);
            millis_q = millis_q + add[MsW-1:0];
            if (64'(ref_tick_q) >= used) begin
              ref_tick_q = CntW'(64'(ref_tick_q) - used);
            end else if (period + 64'(ref_tick_q) >= used) begin
              ref_tick_q = CntW'(period + 64'(ref_tick_q) - used);
            end else begin
              ref_tick_q = '0;
            end
          end
        end
      end
      FuncMsChk: begin
        rep.expired = ((millis_q - ref_req) >= span);
      end
      FuncUsChk: begin
        if (ref_req != 32'(sample)) begin
          rep.expired = (down_ticks(64'(ref_req), 64'(sample)) >= 64'(span) * 64'(tpu_q));
        end
      end
      default: ;
    endcase
    rep.ms_count = millis_q;
    report_q.push_back(rep);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ms_report_t want;
    if (!rst_ni) begin
      reload_q     = ReloadRst;
      tpm_q        = TpmRst;
      tpu_q        = TpuRst;
      ref_tick_q   = '1;
      millis_q     = '0;
      fail_count_o = 0;
      report_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgReload: reload_q = cfg_wdata_i;
          CfgTpm:    tpm_q    = cfg_wdata_i;
          CfgTpu:    tpu_q    = cfg_wdata_i[TpuW-1:0];
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        if (report_q.size() == 0) begin
          $display("%0t: unexpected item: expected none actual ms_count %h expired %b",
                   $time, ms_count_o, expired_o);
          fail_count_o++;
        end else begin
          want = report_q.pop_front();
          if (ms_count_o !== want.ms_count) begin
            $display("%0t: ms_count mismatch: expected %h actual %h",
                     $time, want.ms_count, ms_count_o);
            fail_count_o++;
          end
          if (expired_o !== want.expired) begin
            $display("%0t: expired mismatch: expected %b actual %b",
                     $time, want.expired, expired_o);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        predict_report(func_i, counter_value_i, ref_req_i, span_i);
      end
    end
    pending_o = report_q.size();
  end

endmodule

>>> dv/tb_top.sv
// Top of the down-counter millisecond timebase testbench: clock, reset,
// directed and random items, config phases and the verdict.
// Depends on dcmt_pkg, down_counter_ms_timebase_core and dcmt_timebase_checker.
module tb_top
  import dcmt_pkg::*;
();

  localparam logic [FuncW-1:0]   FuncSpare     = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgSpare      = 2'd3;
  localparam int                 IdleLimit     = 2000;
  localparam int                 Phases        = 7;
  localparam int                 ItemsPerPhase = 100;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx   = '0;
  logic [CfgW-1:0]    cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [FuncW-1:0]   func      = FuncSync;
  logic [CntW-1:0]    counter_value = '0;
  logic [RefW-1:0]    ref_req   = '0;
  logic [RefW-1:0]    span      = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [MsW-1:0]     ms_count;
  logic               expired;

  int                 fail_count;
  int                 pending;
  int                 quiet_cycles = 0;
  bit                 idle_on = 1'b1;
  logic [CfgW-1:0]    reload_m = ReloadRst;
  logic [CfgW-1:0]    tpm_m    = TpmRst;
  logic [TpuW-1:0]    tpu_m    = TpuRst;
  logic [CntW-1:0]    cnt_now  = '1;
  logic [CntW-1:0]    mark_tick = '0;

  down_counter_ms_timebase_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func),
    .counter_value_i(counter_value),
    .ref_req_i      (ref_req),
    .span_i         (span),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .ms_count_o     (ms_count),
    .expired_o      (expired)
  );

  dcmt_timebase_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func),
    .counter_value_i(counter_value),
    .ref_req_i      (ref_req),
    .span_i         (span),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .ms_count_o     (ms_count),
    .expired_o      (expired),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IdleLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [FuncW-1:0] f, input logic [CntW-1:0] sample,
                           input logic [RefW-1:0] rq, input logic [RefW-1:0] sp);
    logic took;
    in_valid      <= 1'b1;
    func          <= f;
    counter_value <= sample;
    ref_req       <= rq;
    span          <= sp;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic pause_until_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CfgReload: begin
        reload_m = value;
        cnt_now  = CntW'($urandom_range(0, 32'(value)));
      end
      CfgTpm: tpm_m = value;
      CfgTpu: tpu_m = value[TpuW-1:0];
      default: ;
    endcase
  endtask

  // advance the modeled counter by up to three milliseconds, wrapping at the period
  task automatic advance_counter();
    logic [63:0] period;
    logic [63:0] reach;
    logic [63:0] dec;
    period = 64'(reload_m) + 64'd1;
    reach  = 64'(tpm_m) * 64'd3;
    if (reach > 64'(reload_m)) reach = 64'(reload_m);
    dec = 64'($urandom_range(0, 32'(reach)));
    if (64'(cnt_now) >= dec) begin
      cnt_now = CntW'(64'(cnt_now) - dec);
    end else begin
      cnt_now = CntW'(64'(cnt_now) + period - dec);
    end
  endtask

  task automatic random_item();
    int pick;
    int span_reach;
    pick = $urandom_range(0, 99);
    span_reach = (4 * int'(tpm_m)) / ((tpu_m == '0) ? 1 : int'(tpu_m)) + 4;
    if (pick < 12) begin
      send_item(FuncW'($urandom_range(0, 3)), CntW'($urandom), $urandom, $urandom);
    end else begin
      advance_counter();
      if ($urandom_range(0, 7) == 0) mark_tick = cnt_now;
      if (pick < 55) begin
        send_item(FuncSync, cnt_now, $urandom, $urandom);
      end else if (pick < 75) begin
        send_item(FuncMsChk, CntW'($urandom), $urandom_range(0, 4000), $urandom_range(0, 4000));
      end else if (pick < 95) begin
        send_item(FuncUsChk, cnt_now, 32'(mark_tick), $urandom_range(0, span_reach));
      end else begin
        send_item(FuncSpare, cnt_now, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    int r;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(FuncSpare, 24'h5A_A5A5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(FuncSync, 24'hFF_FFFF, '0, '0);
    send_item(FuncSync, 24'hFF_FFFF - 24'd100, '0, '0);
    send_item(FuncSync, 24'hFF_FFFF - 24'd120007, '0, '0);
    send_item(FuncSync, 24'h00_0000, '0, '0);
    send_item(FuncSync, 24'hFF_FFF0, '0, '0);
    send_item(FuncMsChk, '0, 32'd0, 32'd0);
    send_item(FuncMsChk, '0, 32'd0, 32'hFFFF_FFFF);
    send_item(FuncMsChk, '0, 32'hFFFF_FFFF, 32'd1);
    send_item(FuncUsChk, 24'd1000, 32'd1000, 32'd0);
    send_item(FuncUsChk, 24'd976, 32'd1000, 32'd1);
    send_item(FuncUsChk, 24'd977, 32'd1000, 32'd1);
    send_item(FuncUsChk, 24'd200, 32'd100, 32'd0);
    send_item(FuncUsChk, 24'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    pause_until_idle();
    write_reg(CfgReload, 24'd99);
    write_reg(CfgTpm, 24'd10);
    write_reg(CfgTpu, 24'd255);
    write_reg(CfgSpare, CfgW'($urandom));
    send_item(FuncSync, 24'd500, '0, '0);
    send_item(FuncUsChk, 24'd500, 32'd5, 32'd0);
    send_item(FuncUsChk, 24'd10, 32'd50, 32'hFFFF_FFFF);
    send_item(FuncSync, 24'd200, '0, '0);

    pause_until_idle();
    write_reg(CfgTpm, 24'd0);
    write_reg(CfgTpu, 24'd0);
    send_item(FuncSync, 24'd0, '0, '0);
    send_item(FuncUsChk, 24'd3, 32'd7, 32'hFFFF_FFFF);

    for (int ph = 0; ph < Phases; ph++) begin
      pause_until_idle();
      case (ph)
        0: begin
          write_reg(CfgReload, ReloadRst);
          write_reg(CfgTpm, TpmRst);
          write_reg(CfgTpu, CfgW'(TpuRst));
        end
        1: begin
          write_reg(CfgReload, 24'd1);
          write_reg(CfgTpm, 24'd1);
          write_reg(CfgTpu, 24'd1);
        end
        2: begin
          write_reg(CfgReload, 24'hFF_FFFF);
          write_reg(CfgTpm, 24'hFF_FFFF);
          write_reg(CfgTpu, 24'd255);
        end
        3: begin
          write_reg(CfgReload, 24'd0);
          write_reg(CfgTpm, 24'd1);
          write_reg(CfgTpu, 24'd0);
        end
        5: begin
          write_reg(CfgReload, CfgW'($urandom));
          write_reg(CfgTpm, CfgW'($urandom));
          write_reg(CfgTpu, CfgW'($urandom));
        end
        default: begin
          r = $urandom_range(1000, 24'hFF_FFFF);
          write_reg(CfgReload, CfgW'(r));
          write_reg(CfgTpm, CfgW'($urandom_range(1, r / 4)));
          write_reg(CfgTpu, CfgW'($urandom_range(0, 255)));
        end
      endcase
      for (int k = 0; k < ItemsPerPhase; k++) begin
        if (ph == Phases - 1) begin
          idle_on = 1'b0;
        end else if (k % 25 == 0) begin
          idle_on = ($urandom_range(0, 3) != 0);
        end
        random_item();
      end
    end

    pause_until_idle();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/dcmt_pkg.sv
rtl/core/dcmt_ctrl.sv
rtl/core/dcmt_dp.sv
rtl/core/down_counter_ms_timebase_core.sv
dv/dcmt_timebase_checker.sv
dv/tb_top.sv
